FILE: src/bqsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsd_pkg
// Types and constants shared by the bounded event queue with selective drop.
// ----------------------------------------------------------------------------
package bqsd_pkg;

	localparam int DATA_W     = 32;
	localparam int OCC_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_FLAG     = 1'b1;

	localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 7'd64;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] event_data;
		logic              is_droppable;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] head_data;
		logic              head_valid;
		logic              empty_error;
		logic              push_accepted;
		logic              evicted_one;
		logic [OCC_W-1:0]  occupancy;
		logic              queue_active;
	} rsp_t;

	typedef struct packed {
		logic pop;
		logic evict;
		logic wr_en;
	} op_t;

endpackage

FILE: src/bounded_queue_selective_drop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_queue_selective_drop
// Bounded event FIFO that pushes out the oldest droppable entry when full.
// ----------------------------------------------------------------------------
// Usage: each transfer on req is one operation, a push (kind 0) of
// event_data with its droppable mark, or a pop (kind 1) of the head entry.
// Every operation yields exactly one transfer on rsp with the popped data,
// the push/evict/error flags, the occupancy after the operation and the
// active flag (entries present and pause_flag clear).
// rsp_valid rises in the cycle after a req transfer; one operation is
// taken every cycle while req_stall is low. The slots form a row of cells;
// a full push finds the oldest droppable entry through a search that
// ripples along the row, and the cells behind it close up in the same cycle.
// req_stall rises only while a result is held and rsp_stall is high; the
// held result and the queue contents stay put until it is taken.
// cfg writes set capacity_limit (index 0) and pause_flag (index 1); cfg_ready
// is always high. Reset empties the queue, sets capacity_limit to 64 and
// clears pause_flag; there is no clearing pass.
// ----------------------------------------------------------------------------
module bounded_queue_selective_drop
	import bqsd_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	logic [CFG_DATA_W-1:0] cap_q;
	logic                  pause_q;
	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [SW-1:0] cell_data [QUEUE_DEPTH+1];
	logic          cell_drop [QUEUE_DEPTH+1];
	logic          hit       [QUEUE_DEPTH+1];

	logic          fire;
	logic          is_push;
	logic          is_pop;
	logic [LW-1:0] cap_ext;
	logic [LW-1:0] lim;
	logic [LW-1:0] cnt_ext;
	logic [LW-1:0] cnt_after;
	logic          full;
	logic          pop_do;
	logic          empty_pop;
	logic          accept;
	logic [CW-1:0] new_count;
	op_t           op;
	rsp_t          rsp_d;

	assign cfg_ready = 1'b1;
	assign req_stall = rsp_valid_q & rsp_stall;
	assign fire      = req_valid & ~req_stall;
	assign is_push   = fire & (req.kind == KIND_PUSH);
	assign is_pop    = fire & (req.kind == KIND_POP);

	always_comb begin
		cap_ext = LW'(cap_q);
		if (cap_ext == '0) begin
			lim = LW'(1);
		end else if (cap_ext > LW'(QUEUE_DEPTH)) begin
			lim = LW'(QUEUE_DEPTH);
		end else begin
			lim = cap_ext;
		end
	end

	assign cnt_ext   = LW'(count_q);
	assign full      = cnt_ext >= lim;
	assign op.evict  = is_push & full & hit[QUEUE_DEPTH];
	assign cnt_after = cnt_ext - LW'(op.evict);
	assign accept    = is_push & (cnt_after < lim);
	assign op.wr_en  = accept;
	assign pop_do    = is_pop & (count_q != '0);
	assign empty_pop = is_pop & (count_q == '0);
	assign op.pop    = pop_do;

	always_comb begin
		if (pop_do) begin
			new_count = count_q - CW'(1);
		end else begin
			new_count = CW'(cnt_after) + CW'(accept);
		end
	end

	assign hit[0]                   = 1'b0;
	assign cell_data[QUEUE_DEPTH]   = '0;
	assign cell_drop[QUEUE_DEPTH]   = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		bqsd_cell #(
			.IDX (i),
			.IW  (IW),
			.CW  (CW),
			.SW  (SW)
		) u_cell (
			.clk      (clk),
			.op       (op),
			.wr_idx   (cnt_after[IW-1:0]),
			.count    (count_q),
			.new_data (SW'(req.event_data)),
			.new_drop (req.is_droppable),
			.nbr_data (cell_data[i+1]),
			.nbr_drop (cell_drop[i+1]),
			.hit_in   (hit[i]),
			.hit_out  (hit[i+1]),
			.data     (cell_data[i]),
			.drop     (cell_drop[i])
		);
	end

	always_comb begin
		rsp_d               = '0;
		rsp_d.head_data     = pop_do ? DATA_W'(cell_data[0]) : '0;
		rsp_d.head_valid    = pop_do;
		rsp_d.empty_error   = empty_pop;
		rsp_d.push_accepted = accept;
		rsp_d.evicted_one   = op.evict;
		rsp_d.occupancy     = OCC_W'(new_count);
		rsp_d.queue_active  = (new_count != '0) & ~pause_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= new_count;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAPACITY_RESET;
			pause_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAPACITY_LIMIT: begin
					cap_q <= cfg_data;
				end
				REG_PAUSE_FLAG: begin
					pause_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: src/bqsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsd_cell
// One queue slot: holds an entry, takes its upper neighbor on a close-up,
// loads a new entry at the tail and ripples the first-droppable search.
// ----------------------------------------------------------------------------
module bqsd_cell
	import bqsd_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int CW  = 7,
	parameter int SW  = 32
) (
	input  logic          clk,
	input  op_t           op,
	input  logic [IW-1:0] wr_idx,
	input  logic [CW-1:0] count,
	input  logic [SW-1:0] new_data,
	input  logic          new_drop,
	input  logic [SW-1:0] nbr_data,
	input  logic          nbr_drop,
	input  logic          hit_in,
	output logic          hit_out,
	output logic [SW-1:0] data,
	output logic          drop
);

	logic [SW-1:0] data_q;
	logic          drop_q;
	logic          occ;
	logic          shift;

	assign occ     = CW'(IDX) < count;
	assign hit_out = hit_in | (occ & drop_q);
	assign shift   = op.pop | (op.evict & hit_out);
	assign data    = data_q;
	assign drop    = drop_q;

	always_ff @(posedge clk) begin
		if (op.wr_en && wr_idx == IW'(IDX)) begin
			data_q <= new_data;
			drop_q <= new_drop;
		end else if (shift) begin
			data_q <= nbr_data;
			drop_q <= nbr_drop;
		end
	end

endmodule

FILE: verif/queue_mirror_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_mirror_pkg
// Shadow copy of the bounded event queue: predicts the reply to each accepted
// operation and checks the replies of the block against it in order.
// ----------------------------------------------------------------------------
package queue_mirror_pkg;
	import bqsd_pkg::*;

	localparam int QUEUE_DEPTH = 64;

	class queue_mirror;
		logic [DATA_W-1:0] payloads[$];
		bit                droppable_marks[$];
		logic [OCC_W-1:0]  capacity_limit;
		logic              pause_flag;
		rsp_t              pending_replies[$];
		int unsigned       mismatches;

		function new();
			capacity_limit = CAPACITY_RESET;
			pause_flag = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_CAPACITY_LIMIT) begin
				capacity_limit = data;
			end else begin
				pause_flag = data[0];
			end
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction

		function void note_op(req_t op);
			rsp_t             r;
			logic [OCC_W-1:0] lim;
			int               hit;
			r = '0;
			lim = capacity_limit;
			if (lim == 0) lim = OCC_W'(1);
			if (lim > QUEUE_DEPTH) lim = OCC_W'(QUEUE_DEPTH);
			if (op.kind == KIND_PUSH) begin
				if (payloads.size() >= lim) begin
					hit = -1;
					foreach (droppable_marks[i]) begin
						if (hit < 0 && droppable_marks[i]) hit = i;
					end
					if (hit >= 0) begin
						payloads.delete(hit);
						droppable_marks.delete(hit);
						r.evicted_one = 1'b1;
					end
				end
				if (payloads.size() < lim) begin
					payloads.push_back(op.event_data);
					droppable_marks.push_back(op.is_droppable);
					r.push_accepted = 1'b1;
				end
			end else if (payloads.size() == 0) begin
				r.empty_error = 1'b1;
			end else begin
				r.head_data = payloads[0];
				payloads.delete(0);
				droppable_marks.delete(0);
				r.head_valid = 1'b1;
			end
			r.occupancy = OCC_W'(payloads.size());
			r.queue_active = (payloads.size() != 0) && !pause_flag;
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t: reply with nothing pending, expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_replies[0];
			pending_replies.delete(0);
			compare_field("head_data", want.head_data, got.head_data);
			compare_field("head_valid", DATA_W'(want.head_valid), DATA_W'(got.head_valid));
			compare_field("empty_error", DATA_W'(want.empty_error), DATA_W'(got.empty_error));
			compare_field("push_accepted", DATA_W'(want.push_accepted),
				DATA_W'(got.push_accepted));
			compare_field("evicted_one", DATA_W'(want.evicted_one), DATA_W'(got.evicted_one));
			compare_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
			compare_field("queue_active", DATA_W'(want.queue_active),
				DATA_W'(got.queue_active));
		endfunction
	endclass

endpackage

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop operations into the bounded event queue with random
// gaps and stalls on both sides, sweeps capacity and pause settings between
// phases, and checks every reply against a shadow copy of the queue.
// ----------------------------------------------------------------------------
module testbench;
	import bqsd_pkg::*;
	import queue_mirror_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 200;
	localparam int IDLE_CYCLES    = 3;
	localparam int SETTLE_CYCLES  = 8;
	localparam int NUM_PHASES     = 14;
	localparam int PHASE_OPS      = 138;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	queue_mirror mirror;
	int          gap_max;
	int          cap_table[NUM_PHASES] = '{64, 1, 2, 127, 0, 3, 65, 8, 64, 16, 1, 32, 127, 5};

	bounded_queue_selective_drop i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic req_t make_op(logic kind, logic [DATA_W-1:0] data, logic drop);
		req_t o;
		o.kind = kind;
		o.event_data = data;
		o.is_droppable = drop;
		return o;
	endfunction

	function automatic req_t random_op(int push_pct, int drop_pct);
		req_t o;
		o.kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
		o.event_data = $urandom();
		o.is_droppable = ($urandom_range(0, 99) < drop_pct);
		return o;
	endfunction

	task automatic send_op(req_t item);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && !req_stall));
		mirror.note_op(item);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (mirror.outstanding() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		mirror.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receive side: random stall per transfer, two long hold-offs
	initial begin
		int   g;
		int   taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == 400 || taken == 1300) g = HOLD_CYCLES;
			else g = $urandom_range(0, gap_max);
			if (g > 0) begin
				rsp_stall <= 1'b1;
				repeat (g) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
			mirror.check_reply(rsp);
			taken++;
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int                    p;
		int                    push_pct;
		int                    drop_pct;
		logic [CFG_DATA_W-1:0] pause_word;

		mirror = new();
		gap_max = 15;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CAPACITY_LIMIT;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(make_op(KIND_POP, 32'h0, 1'b0));
		send_op(make_op(KIND_PUSH, 32'hFFFF_FFFF, 1'b1));
		send_op(make_op(KIND_PUSH, 32'h0000_0000, 1'b0));
		send_op(make_op(KIND_POP, 32'hFFFF_FFFF, 1'b1));

		// limit of zero acts as one
		wait_idle();
		write_reg(REG_CAPACITY_LIMIT, 7'd0);
		send_op(make_op(KIND_PUSH, 32'hA5A5_A5A5, 1'b1));
		send_op(make_op(KIND_POP, 32'h0, 1'b0));
		send_op(make_op(KIND_PUSH, 32'h1234_5678, 1'b1));
		send_op(make_op(KIND_PUSH, 32'h9ABC_DEF0, 1'b0));
		send_op(make_op(KIND_POP, 32'h0, 1'b0));

		wait_idle();
		write_reg(REG_CAPACITY_LIMIT, 7'd64);
		write_reg(REG_PAUSE_FLAG, 7'd1);
		send_op(make_op(KIND_PUSH, 32'h1111_1111, 1'b0));
		send_op(make_op(KIND_PUSH, 32'h2222_2222, 1'b1));
		send_op(make_op(KIND_PUSH, 32'h3333_3333, 1'b0));
		send_op(make_op(KIND_PUSH, 32'h4444_4444, 1'b1));
		send_op(make_op(KIND_PUSH, 32'h5555_5555, 1'b0));

		// lower the limit below the count: evict without storing
		wait_idle();
		write_reg(REG_CAPACITY_LIMIT, 7'd2);
		send_op(make_op(KIND_PUSH, 32'h6666_6666, 1'b1));
		send_op(make_op(KIND_PUSH, 32'h7777_7777, 1'b0));
		send_op(make_op(KIND_PUSH, 32'h8888_8888, 1'b1));
		repeat (4) send_op(make_op(KIND_POP, 32'hFFFF_FFFF, 1'b1));

		for (p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_reg(REG_CAPACITY_LIMIT, CFG_DATA_W'(cap_table[p]));
			pause_word = CFG_DATA_W'(($urandom_range(0, 63) << 1) | (p % 2));
			write_reg(REG_PAUSE_FLAG, pause_word);
			gap_max = (p % 5 == 2) ? 0 : 15;
			push_pct = (p % 3 == 0) ? 85 : $urandom_range(35, 80);
			if (p == 4) drop_pct = 0;
			else if (p == 7) drop_pct = 100;
			else drop_pct = $urandom_range(0, 100);
			repeat (PHASE_OPS) send_op(random_op(push_pct, drop_pct));
		end

		req_valid <= 1'b0;
		while (mirror.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/bqsd_pkg.sv
src/bqsd_cell.sv
src/bounded_queue_selective_drop.sv
verif/queue_mirror_pkg.sv
verif/testbench.sv
